// ----- sv/afu_pkg.sv -----
// ----------------------------------------------------------------------------
// afu_pkg
// Field types and mode codes shared by the activation function unit.
// ----------------------------------------------------------------------------
`default_nettype none

package afu_pkg;

  localparam int X_W    = 16;
  localparam int ACT_W  = 16;
  localparam int DER_W  = 13;
  localparam int MODE_W = 3;

  typedef logic signed [X_W-1:0]   x_t;
  typedef logic signed [ACT_W-1:0] act_t;
  typedef logic [DER_W-1:0]        der_t;
  typedef logic [MODE_W-1:0]       mode_t;

  localparam mode_t MODE_LINEAR  = 3'd0;
  localparam mode_t MODE_SIGMOID = 3'd1;
  localparam mode_t MODE_BIPOLAR = 3'd2;
  localparam mode_t MODE_TANH    = 3'd3;
  localparam mode_t MODE_RELU    = 3'd4;

endpackage

`default_nettype wire

// ----- sv/activation_function_unit_top.sv -----
// ----------------------------------------------------------------------------
// activation_function_unit_top
// Activation and derivative of a signed fixed-point value: linear, logistic
// sigmoid, bipolar sigmoid, tanh or ReLU, selected by the mode register.
// ----------------------------------------------------------------------------
`default_nettype none

// The unit takes one x_value transaction per clock while out_ready stays
// high and returns one result transaction for each, in order. The input
// register loads at the accepting edge. Then the register after the sigmoid
// table read loads; the clamp, index scaling and the SIG_TABLE_DEPTH-entry
// lookup sit in that stage. The result register loads after it, behind the
// single s*(1-s) product that feeds the sigmoid, bipolar and tanh derivatives.
// The sustained rate is one item per cycle while out_ready stays high; the
// stages hold in place while the output stalls. The sigmoid table is a
// constant computed at elaboration. Write cfg_mode only while no transaction
// is in flight.
module activation_function_unit_top #(
  parameter int SIG_TABLE_DEPTH = 1024,
  parameter int FRAC_BITS       = 12
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire afu_pkg::mode_t  cfg_mode,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire afu_pkg::x_t     x_value,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output afu_pkg::act_t        activation,
  output afu_pkg::der_t        derivative
);

  import afu_pkg::*;

  localparam int ROM_W  = FRAC_BITS + 1;
  localparam int IDX_W  = $clog2(SIG_TABLE_DEPTH);
  localparam int DEP_W  = $clog2(SIG_TABLE_DEPTH + 1);
  localparam int OFF_W  = FRAC_BITS + 4;
  localparam int VW     = (FRAC_BITS + 5 > X_W + 1) ? FRAC_BITS + 5 : X_W + 1;
  localparam int EW     = 2 * ROM_W + 2;
  localparam int ONE_I  = 1 << FRAC_BITS;

  localparam logic signed [VW-1:0] SPAN_LO = VW'(-8 * ONE_I);
  localparam logic signed [VW-1:0] SPAN_HI = VW'(8 * ONE_I - 1);
  localparam logic [DEP_W-1:0]     DEPTH_C = DEP_W'(SIG_TABLE_DEPTH);
  localparam logic [ROM_W-1:0]     ONE_R   = ROM_W'(ONE_I);
  localparam logic [EW-1:0]        ONE_E   = EW'(ONE_I);
  localparam logic [EW-1:0]        HALF_E  = EW'(ONE_I / 2);
  localparam logic [EW-1:0]        ONE_SQ  = ONE_E << FRAC_BITS;

  typedef logic [ROM_W-1:0] rom_t [SIG_TABLE_DEPTH];

  // Shift-subtract division for the elaboration-time table build.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry i samples s(-8 + 16*i/DEPTH); exp(-|x|) from a 16-term series at
  // |x|/16, squared four times.
  function automatic rom_t build_sig_rom();
    rom_t        rom;
    longint      num;
    logic [63:0] mag;
    logic [63:0] u;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] p;
    for (int i = 0; i < SIG_TABLE_DEPTH; i++) begin
      num  = 16 * longint'(i) - 8 * longint'(SIG_TABLE_DEPTH);
      mag  = (num < 0) ? 64'(-num) : 64'(num);
      u    = (mag << 27) / SIG_TABLE_DEPTH;
      term = 64'd1 << 31;
      pos  = term;
      neg  = '0;
      for (int n = 1; n <= 16; n++) begin
        term = udiv64((term * u) >> 31, 64'(n));
        if ((n & 1) != 0) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      e = (pos > neg) ? pos - neg : 64'd0;
      if (e > (64'd1 << 31)) begin
        e = 64'd1 << 31;
      end
      for (int k = 0; k < 4; k++) begin
        e = (e * e + (64'd1 << 30)) >> 31;
      end
      den    = (64'd1 << 31) + e;
      p      = udiv64((64'd1 << (FRAC_BITS + 31)) + (den >> 1), den);
      rom[i] = (num < 0) ? ROM_W'((64'd1 << FRAC_BITS) - p) : ROM_W'(p);
    end
    return rom;
  endfunction

  localparam rom_t SIG_ROM = build_sig_rom();

  // Configuration
  mode_t mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_LINEAR;
    end else if (cfg_valid) begin
      mode <= cfg_mode;
    end
  end

  // Pipeline control
  logic s1_valid;
  logic s2_valid;
  logic s1_ready;
  logic s2_ready;
  logic s3_ready;

  assign s3_ready = !out_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  // Stage 1: input register
  x_t s1_x;

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_x <= x_value;
    end
  end

  // Stage 2: clamp, index and table read
  logic signed [VW-1:0]     xe;
  logic signed [VW-1:0]     v;
  logic signed [VW-1:0]     vc;
  logic signed [VW-1:0]     off_full;
  logic [OFF_W+DEP_W-1:0]   idx_prod;
  logic [IDX_W-1:0]         idx;
  x_t                       s2_x;
  logic [ROM_W-1:0]         s2_sig;

  always_comb begin
    xe = VW'(s1_x);
    v  = (mode == MODE_TANH) ? (xe <<< 1) : xe;
    if (v < SPAN_LO) begin
      vc = SPAN_LO;
    end else if (v > SPAN_HI) begin
      vc = SPAN_HI;
    end else begin
      vc = v;
    end
    off_full = vc - SPAN_LO;
    idx_prod = (OFF_W + DEP_W)'(off_full[OFF_W-1:0]) * (OFF_W + DEP_W)'(DEPTH_C);
    idx      = idx_prod[OFF_W +: IDX_W];
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_x   <= s1_x;
      s2_sig <= SIG_ROM[idx];
    end
  end

  // Stage 3: derivative product and result register
  logic [ROM_W-1:0] one_minus;
  logic [EW-1:0]    prod;
  logic [EW-1:0]    sig_der;
  logic [EW-1:0]    bip_der;
  logic [EW-1:0]    tanh_sq;
  logic [EW-1:0]    tanh_der;
  logic [EW-1:0]    bip_act;
  act_t             act_next;
  der_t             der_next;

  always_comb begin
    one_minus = ONE_R - s2_sig;
    prod      = EW'(s2_sig) * EW'(one_minus);
    sig_der   = (prod + HALF_E) >> FRAC_BITS;
    bip_der   = ((prod << 2) + ONE_E) >> (FRAC_BITS + 1);
    // t*t equals one squared minus 4*s*(1-s)
    tanh_sq   = (ONE_SQ - (prod << 2) + HALF_E) >> FRAC_BITS;
    tanh_der  = ONE_E - tanh_sq;
    bip_act   = (EW'(s2_sig) << 1) - ONE_E;
    case (mode)
      MODE_LINEAR: begin
        act_next = s2_x;
        der_next = ONE_E[DER_W-1:0];
      end
      MODE_SIGMOID: begin
        act_next = act_t'(EW'(s2_sig));
        der_next = sig_der[DER_W-1:0];
      end
      MODE_BIPOLAR: begin
        act_next = bip_act[ACT_W-1:0];
        der_next = bip_der[DER_W-1:0];
      end
      MODE_TANH: begin
        act_next = bip_act[ACT_W-1:0];
        der_next = tanh_der[DER_W-1:0];
      end
      MODE_RELU: begin
        act_next = (s2_x > 0) ? s2_x : '0;
        der_next = (s2_x > 0) ? ONE_E[DER_W-1:0] : '0;
      end
      default: begin
        act_next = '0;
        der_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      activation <= act_next;
      derivative <= der_next;
    end
  end

  // Assertions
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_ready |=> s1_valid && $stable(s1_x))
    else $error("stage 1 lost its transaction during a stall");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_ready |=> s2_valid && $stable(s2_sig) && $stable(s2_x))
    else $error("stage 2 lost its transaction during a stall");

  a_sig_range: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> s2_sig <= ONE_R)
    else $error("sigmoid table value above one");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s3_ready |=> out_valid)
    else $error("stage 2 transaction did not reach the result register");

endmodule

`default_nettype wire
